[design/qnl_pkg.sv]
// Shared types, widths and saturation helpers for the quaternion nlerp pipeline.
package qnl_pkg;

  localparam int COMP_WIDTH = 16;

  localparam int Lanes    = 4;
  localparam int WeightW  = 15;
  localparam int Frac     = 14;
  localparam int ElemW    = 16;
  localparam int DotW     = 2 * ElemW + 2;
  localparam int DiffW    = ElemW + 2;
  localparam int ProdW    = DiffW + WeightW + 1;
  localparam int VecW     = 19;
  localparam int MagW     = VecW - 1;
  localparam int SqW      = 35;
  localparam int LenW     = SqW + 2;
  localparam int QuoW     = 31;
  localparam int RootW    = 16;
  localparam int SqRemW   = RootW + 2;
  localparam int DivSteps  = QuoW;
  localparam int SqrtSteps = RootW;
  localparam int FrontStages = 6;
  localparam int PipeDepth = FrontStages + DivSteps + SqrtSteps + 1;
  localparam int RoundHalf = 2 ** (Frac - 1);
  localparam int WideW = 33;

  localparam logic signed [WideW-1:0] InHi  = WideW'(2 ** (ElemW - 1) - 1);
  localparam logic signed [WideW-1:0] InLo  = -InHi - WideW'(1);
  localparam longint                  OutHiL = (longint'(1) <<< (COMP_WIDTH - 1)) - 1;
  localparam logic signed [WideW-1:0] OutHi = WideW'(OutHiL);
  localparam logic signed [WideW-1:0] OutLo = -OutHi - WideW'(1);

  typedef logic signed [COMP_WIDTH-1:0] comp_t;

  typedef struct packed {
    comp_t               p_w;
    comp_t               p_x;
    comp_t               p_y;
    comp_t               p_z;
    comp_t               q_w;
    comp_t               q_x;
    comp_t               q_y;
    comp_t               q_z;
    logic [WeightW-1:0]  blend_weight;
  } qnl_in_t;

  typedef struct packed {
    comp_t r_w;
    comp_t r_x;
    comp_t r_y;
    comp_t r_z;
    logic  zero_length;
  } qnl_out_t;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [Lanes-1:0] neg;
  } qnl_tag_t;

  function automatic logic signed [ElemW-1:0] sat_in(comp_t x);
    logic signed [WideW-1:0] w;
    w = WideW'(x);
    if (w > InHi) begin
      sat_in = ElemW'(InHi);
    end else if (w < InLo) begin
      sat_in = ElemW'(InLo);
    end else begin
      sat_in = ElemW'(w);
    end
  endfunction

  function automatic comp_t sat_out(logic signed [RootW:0] r);
    logic signed [WideW-1:0] w;
    w = WideW'(r);
    if (w > OutHi) begin
      sat_out = COMP_WIDTH'(OutHi);
    end else if (w < OutLo) begin
      sat_out = COMP_WIDTH'(OutLo);
    end else begin
      sat_out = COMP_WIDTH'(w);
    end
  endfunction

endpackage

[design/qnl_norm.sv]
// Pipelined restoring divide of v^2*2^30 by the squared length, then integer square root.
module qnl_norm (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  qnl_pkg::qnl_tag_t                              tag_i,
  input  logic [qnl_pkg::LenW-1:0]                       len_i,
  input  logic [qnl_pkg::Lanes-1:0][qnl_pkg::SqW-1:0]    sq_i,
  output qnl_pkg::qnl_tag_t                              tag_o,
  output logic [qnl_pkg::Lanes-1:0][qnl_pkg::RootW-1:0]  root_o
);
  import qnl_pkg::*;

  // divider stages: one quotient bit each
  qnl_tag_t          dtag_q [DivSteps];
  logic [LenW-1:0]   dlen_q [DivSteps];
  logic [LenW-1:0]   drem_q [DivSteps][Lanes];
  logic [LenW-1:0]   drem_d [DivSteps][Lanes];
  logic [QuoW-1:0]   dquo_q [DivSteps][Lanes];
  logic [QuoW-1:0]   dquo_d [DivSteps][Lanes];
  logic [LenW:0]     drs    [DivSteps][Lanes];
  logic [QuoW-1:0]   dqin   [DivSteps][Lanes];
  logic [LenW:0]     ddv    [DivSteps];
  logic              dge    [DivSteps][Lanes];

  // square root stages: one root bit each
  qnl_tag_t            stag_q  [SqrtSteps];
  logic [SqRemW-1:0]   srem_q  [SqrtSteps][Lanes];
  logic [SqRemW-1:0]   srem_d  [SqrtSteps][Lanes];
  logic [RootW-1:0]    sroot_q [SqrtSteps][Lanes];
  logic [RootW-1:0]    sroot_d [SqrtSteps][Lanes];
  logic [2*RootW-1:0]  sx_q    [SqrtSteps][Lanes];
  logic [2*RootW-1:0]  sx_d    [SqrtSteps][Lanes];
  logic [SqRemW+1:0]   srs     [SqrtSteps][Lanes];
  logic [SqRemW+1:0]   strial  [SqrtSteps][Lanes];
  logic [SqRemW-1:0]   srin    [SqrtSteps][Lanes];
  logic [RootW-1:0]    srootin [SqrtSteps][Lanes];
  logic [2*RootW-1:0]  sxin    [SqrtSteps][Lanes];
  logic                sge     [SqrtSteps][Lanes];

  always_comb begin
    ddv[0] = {1'b0, len_i};
    for (int l = 0; l < Lanes; l++) begin
      drs[0][l]  = (LenW + 1)'(sq_i[l]);
      dqin[0][l] = '0;
    end
    for (int k = 1; k < DivSteps; k++) begin
      ddv[k] = {1'b0, dlen_q[k-1]};
      for (int l = 0; l < Lanes; l++) begin
        drs[k][l]  = {drem_q[k-1][l], 1'b0};
        dqin[k][l] = dquo_q[k-1][l];
      end
    end
    for (int k = 0; k < DivSteps; k++) begin
      for (int l = 0; l < Lanes; l++) begin
        dge[k][l]    = drs[k][l] >= ddv[k];
        drem_d[k][l] = dge[k][l] ? LenW'(drs[k][l] - ddv[k]) : LenW'(drs[k][l]);
        dquo_d[k][l] = {dqin[k][l][QuoW-2:0], dge[k][l]};
      end
    end
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      srin[0][l]    = '0;
      srootin[0][l] = '0;
      sxin[0][l]    = (2 * RootW)'(dquo_q[DivSteps-1][l]);
    end
    for (int k = 1; k < SqrtSteps; k++) begin
      for (int l = 0; l < Lanes; l++) begin
        srin[k][l]    = srem_q[k-1][l];
        srootin[k][l] = sroot_q[k-1][l];
        sxin[k][l]    = sx_q[k-1][l];
      end
    end
    for (int k = 0; k < SqrtSteps; k++) begin
      for (int l = 0; l < Lanes; l++) begin
        srs[k][l]     = {srin[k][l], sxin[k][l][2*RootW-1 -: 2]};
        strial[k][l]  = {2'b00, srootin[k][l], 2'b01};
        sge[k][l]     = srs[k][l] >= strial[k][l];
        srem_d[k][l]  = sge[k][l] ? SqRemW'(srs[k][l] - strial[k][l]) : SqRemW'(srs[k][l]);
        sroot_d[k][l] = {srootin[k][l][RootW-2:0], sge[k][l]};
        sx_d[k][l]    = {sxin[k][l][2*RootW-3:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivSteps; k++) begin
        dtag_q[k] <= '0;
      end
      for (int k = 0; k < SqrtSteps; k++) begin
        stag_q[k] <= '0;
      end
    end else begin
      dtag_q[0] <= tag_i;
      for (int k = 1; k < DivSteps; k++) begin
        dtag_q[k] <= dtag_q[k-1];
      end
      stag_q[0] <= dtag_q[DivSteps-1];
      for (int k = 1; k < SqrtSteps; k++) begin
        stag_q[k] <= stag_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dlen_q[0] <= len_i;
    for (int k = 1; k < DivSteps; k++) begin
      dlen_q[k] <= dlen_q[k-1];
    end
    for (int k = 0; k < DivSteps; k++) begin
      for (int l = 0; l < Lanes; l++) begin
        drem_q[k][l] <= drem_d[k][l];
        dquo_q[k][l] <= dquo_d[k][l];
      end
    end
    for (int k = 0; k < SqrtSteps; k++) begin
      for (int l = 0; l < Lanes; l++) begin
        srem_q[k][l]  <= srem_d[k][l];
        sroot_q[k][l] <= sroot_d[k][l];
        sx_q[k][l]    <= sx_d[k][l];
      end
    end
  end

  assign tag_o = stag_q[SqrtSteps-1];
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      root_o[l] = sroot_q[SqrtSteps-1][l];
    end
  end

endmodule

[design/quaternion_nlerp.sv]
// Top level: normalized linear interpolation of two Q1.14 quaternions.
// Usage:
//   A beat is taken on every rising edge with start high and busy low. busy
//   is held low, so one beat can enter in every cycle and many are in flight.
//   Each result is shown for one cycle with done_o high, in the order the
//   beats came in. The receiver cannot hold results off and none are needed:
//   nothing ever waits inside the block. Throughput is one beat per cycle.
//   The pipeline is six front stages (products, dot sign, blend multiply,
//   rounding, squares, length sum), 31 divider stages giving one quotient
//   bit each, 16 root stages giving one root bit each, and the output
//   register. The shortest_path bit is written with cfg_we_i/cfg_wdata_i;
//   the user must write it only while no beat is in flight, as the block
//   itself does not enforce this. Reset sets it to 1.
//   Reset clears every valid bit, so beats in flight are dropped and done_o
//   stays low until a new beat has gone through.
module quaternion_nlerp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  qnl_pkg::qnl_in_t    in_i,
  output logic                done_o,
  output qnl_pkg::qnl_out_t   result_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);
  import qnl_pkg::*;

  logic sp_q;
  logic [FrontStages-1:0] vld_q;

  logic signed [ElemW-1:0]    p_in [Lanes];
  logic signed [ElemW-1:0]    q_in [Lanes];

  logic signed [ElemW-1:0]    p1_q  [Lanes];
  logic signed [ElemW-1:0]    q1_q  [Lanes];
  logic signed [2*ElemW-1:0]  pq1_q [Lanes];
  logic [WeightW-1:0]         t1_q;

  logic signed [DotW-1:0]     dot2;
  logic                       neg2;
  logic signed [DiffW-1:0]    d2_q [Lanes];
  logic signed [ElemW-1:0]    p2_q [Lanes];
  logic [WeightW-1:0]         t2_q;

  logic signed [ProdW-1:0]    prod3_q [Lanes];
  logic signed [ElemW-1:0]    p3_q    [Lanes];

  logic signed [ProdW-1:0]    msum4 [Lanes];
  logic [VecW-1:0]            v4_q  [Lanes];

  logic [VecW-1:0]            vabs5 [Lanes];
  logic [MagW-1:0]            mag5  [Lanes];
  logic [SqW-1:0]             sq5_q [Lanes];
  logic [Lanes-1:0]           neg5_q;

  logic [LenW-1:0]               lsum6;
  logic [LenW-1:0]               len6_q;
  logic [Lanes-1:0][SqW-1:0]     sq6_q;
  logic [Lanes-1:0]              neg6_q;
  logic                          zero6_q;

  qnl_tag_t                      tag6;
  qnl_tag_t                      ntag;
  logic [Lanes-1:0][RootW-1:0]   nroot;

  logic [RootW:0]              rup   [Lanes];
  logic signed [RootW:0]       rsig  [Lanes];
  comp_t                       rout  [Lanes];
  qnl_out_t                    res_d;
  qnl_out_t                    res_q;
  logic                        done_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= 1'b1;
    end else if (cfg_we_i) begin
      sp_q <= cfg_wdata_i;
    end
  end

  assign p_in[0] = sat_in(in_i.p_w);
  assign p_in[1] = sat_in(in_i.p_x);
  assign p_in[2] = sat_in(in_i.p_y);
  assign p_in[3] = sat_in(in_i.p_z);
  assign q_in[0] = sat_in(in_i.q_w);
  assign q_in[1] = sat_in(in_i.q_x);
  assign q_in[2] = sat_in(in_i.q_y);
  assign q_in[3] = sat_in(in_i.q_z);

  always_comb begin
    dot2 = DotW'(pq1_q[0]) + DotW'(pq1_q[1]) + DotW'(pq1_q[2]) + DotW'(pq1_q[3]);
    neg2 = dot2[DotW-1] & sp_q;
    for (int l = 0; l < Lanes; l++) begin
      msum4[l] = prod3_q[l] + (ProdW'(p3_q[l]) <<< Frac) + ProdW'(RoundHalf);
      vabs5[l] = v4_q[l][VecW-1] ? VecW'(-$signed(v4_q[l])) : v4_q[l];
      mag5[l]  = vabs5[l][MagW-1:0];
    end
    lsum6 = LenW'(sq5_q[0]) + LenW'(sq5_q[1]) + LenW'(sq5_q[2]) + LenW'(sq5_q[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[FrontStages-2:0], start & ~busy};
      done_q <= ntag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < Lanes; l++) begin
      // stage 1: saturate and form p*q
      p1_q[l]  <= p_in[l];
      q1_q[l]  <= q_in[l];
      pq1_q[l] <= p_in[l] * q_in[l];
      // stage 2: dot sign picks q or -q, keep q' - p
      d2_q[l]  <= neg2 ? (-DiffW'(q1_q[l]) - DiffW'(p1_q[l]))
                       : (DiffW'(q1_q[l]) - DiffW'(p1_q[l]));
      p2_q[l]  <= p1_q[l];
      // stage 3: (q' - p) * t
      prod3_q[l] <= d2_q[l] * $signed({1'b0, t2_q});
      p3_q[l]    <= p2_q[l];
      // stage 4: add p at scale 2^14, round half up to Q.14
      v4_q[l]  <= msum4[l][Frac+VecW-1:Frac];
      // stage 5: squares
      sq5_q[l]  <= SqW'(mag5[l]) * SqW'(mag5[l]);
      neg5_q[l] <= v4_q[l][VecW-1];
      // stage 6: squared length
      sq6_q[l]  <= sq5_q[l];
    end
    t1_q    <= in_i.blend_weight;
    t2_q    <= t1_q;
    len6_q  <= lsum6;
    neg6_q  <= neg5_q;
    zero6_q <= (lsum6 == '0);
  end

  assign tag6 = '{valid: vld_q[FrontStages-1], zero: zero6_q, neg: neg6_q};

  qnl_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag6),
    .len_i  (len6_q),
    .sq_i   (sq6_q),
    .tag_o  (ntag),
    .root_o (nroot)
  );

  // r = (isqrt(quo) + 1) / 2, signed, saturated
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      rup[l]  = {1'b0, nroot[l]} + (RootW + 1)'(1);
      rsig[l] = ntag.neg[l] ? -$signed({1'b0, rup[l][RootW:1]})
                            : $signed({1'b0, rup[l][RootW:1]});
      rout[l] = ntag.zero ? '0 : sat_out(rsig[l]);
    end
    res_d.r_w         = rout[0];
    res_d.r_x         = rout[1];
    res_d.r_y         = rout[2];
    res_d.r_z         = rout[3];
    res_d.zero_length = ntag.zero;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##PipeDepth done_o)
    else $error("accepted beat did not complete after the pipeline depth");

  a_zero_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[FrontStages-1] && zero6_q) |-> ##(DivSteps + SqrtSteps + 1)
    (done_o && result_o.zero_length))
    else $error("zero length beat lost its flag in the normalizer");

  a_unit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.zero_length) |->
    (result_o.r_w != '0 || result_o.r_x != '0 || result_o.r_y != '0 ||
     result_o.r_z != '0))
    else $error("nonzero length gave an all zero result");
`endif

endmodule
